// ===== src/mcfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfb_pkg
// Shared types and constants of the motor command frame builder.
// ----------------------------------------------------------------------------
package mcfb_pkg;

  // Operation codes
  localparam logic [2:0] OP_MIT     = 3'd0;
  localparam logic [2:0] OP_REQUEST = 3'd1;
  localparam logic [2:0] OP_ENABLE  = 3'd2;
  localparam logic [2:0] OP_DISABLE = 3'd3;
  localparam logic [2:0] OP_ZERO    = 3'd4;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_LIMIT = 2'd1;
  localparam logic [1:0] STAT_BADOP = 2'd2;

  // Bus numbers that matter
  localparam logic [2:0] BUS_SPINE = 3'd5;

  // Frame constants
  localparam logic [7:0]  SYNC0        = 8'hAA;
  localparam logic [7:0]  SYNC1        = 8'h09;
  localparam logic [7:0]  REG_READ     = 8'h33;
  localparam logic [10:0] REQ_CANID    = 11'h7FF;
  localparam logic [7:0]  FILL_BYTE    = 8'hFF;
  localparam logic [7:0]  CODE_ENABLE  = 8'hFC;
  localparam logic [7:0]  CODE_DISABLE = 8'hFD;
  localparam logic [7:0]  CODE_ZERO    = 8'hFE;

  // Frame byte positions
  localparam logic [3:0] IDX_SYNC0 = 4'd0;
  localparam logic [3:0] IDX_SYNC1 = 4'd1;
  localparam logic [3:0] IDX_BUS   = 4'd2;
  localparam logic [3:0] IDX_IDHI  = 4'd3;
  localparam logic [3:0] IDX_IDLO  = 4'd4;
  localparam logic [3:0] IDX_PAY0  = 4'd5;
  localparam logic [3:0] IDX_PAY7  = 4'd12;
  localparam logic [3:0] IDX_SUM   = 4'd13;

  // Position limits in Q32 radians
  localparam logic [63:0] LIM_PI_Q32  = 64'd13493037705;
  localparam logic [63:0] LIM_30_Q32  = 64'd2248839617;
  localparam logic [63:0] LIM_40_Q32  = 64'd2998452823;
  localparam logic [63:0] LIM_60_Q32  = 64'd4497679235;
  localparam logic [63:0] LIM_135_Q32 = 64'd10119778278;

  // Quantizer widths
  localparam int NCH    = 5;
  localparam int QU_W   = 27;   // scaled dividend, always below 2^22
  localparam int QUO_W  = 16;   // quotient
  localparam int DV_W   = 9;    // span in half units
  localparam int RCP_W  = 28;   // reciprocal of a span
  localparam int RCP_SH = 31;   // reciprocal scale, exact for dividends below 2^22

  // Span of each channel in half units
  localparam logic [DV_W-1:0] SPAN_POS     = 9'd50;
  localparam logic [DV_W-1:0] SPAN_VEL_BIG = 9'd400;
  localparam logic [DV_W-1:0] SPAN_VEL_SML = 9'd260;
  localparam logic [DV_W-1:0] SPAN_TAU_BIG = 9'd120;
  localparam logic [DV_W-1:0] SPAN_TAU_SML = 9'd72;
  localparam logic [DV_W-1:0] SPAN_KP      = 9'd100;
  localparam logic [DV_W-1:0] SPAN_KD      = 9'd10;

  // Reciprocal of each span, ceil(2^31 / span)
  localparam logic [RCP_W-1:0] RCP_POS     = 28'd42949673;
  localparam logic [RCP_W-1:0] RCP_VEL_BIG = 28'd5368710;
  localparam logic [RCP_W-1:0] RCP_VEL_SML = 28'd8259553;
  localparam logic [RCP_W-1:0] RCP_TAU_BIG = 28'd17895698;
  localparam logic [RCP_W-1:0] RCP_TAU_SML = 28'd29826162;
  localparam logic [RCP_W-1:0] RCP_KP      = 28'd21474837;
  localparam logic [RCP_W-1:0] RCP_KD      = 28'd214748365;

  typedef struct packed {
    logic [1:0]      status;
    logic            port;
    logic [2:0]      bus;
    logic [10:0]     canid;
    logic [7:0][7:0] pay;
  } mcfb_rec_t;

endpackage

// ===== src/mcfb_if.sv =====
// ----------------------------------------------------------------------------
// mcfb interfaces
// Command, result and configuration channels of the frame builder.
// ----------------------------------------------------------------------------
interface mcfb_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [2:0]         bus_number;
  logic [15:0]        motor_number;
  logic [7:0]         register_id;
  logic               register_given;
  logic signed [31:0] position_target;
  logic signed [31:0] velocity_target;
  logic signed [31:0] torque_target;
  logic signed [31:0] stiffness_gain;
  logic signed [31:0] damping_gain;

  modport source (output valid, operation, bus_number, motor_number, register_id,
                  register_given, position_target, velocity_target, torque_target,
                  stiffness_gain, damping_gain, input ready);
  modport sink (input valid, operation, bus_number, motor_number, register_id,
                register_given, position_target, velocity_target, torque_target,
                stiffness_gain, damping_gain, output ready);
endinterface

interface mcfb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  logic       serial_port;
  logic [1:0] status;

  modport source (output valid, out_byte, last_byte, serial_port, status, input ready);
  modport sink (input valid, out_byte, last_byte, serial_port, status, output ready);
endinterface

interface mcfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== src/motor_command_frame_builder_unit.sv =====
// ----------------------------------------------------------------------------
// motor_command_frame_builder_unit
// Turns motor commands into 14-byte serial adapter frames, one byte per
// output transaction.
// ----------------------------------------------------------------------------
// A command transaction on in_cmd produces either a full 14-byte frame on
// out_res (sync bytes, remapped bus, CAN id, eight payload bytes, checksum),
// or a single status transaction when the command is rejected. The back end
// emits one byte per cycle while out_res.ready is held high. A MIT command
// passes three steps in the front end: it forms the scaled dividends, then
// multiplies each by the reciprocal of its span in five parallel quantizers,
// and then hands the record to the queue; other commands skip the quantizer
// steps. A two-entry queue lets the front prepare the next command while
// the back end is still sending a frame. The default register is written
// through cfg_wr; the user must write it only while the block idles, as the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module motor_command_frame_builder_unit
  import mcfb_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic       clk,
  input  logic       rst_n,
  mcfb_cmd_if.sink   in_cmd,
  mcfb_res_if.source out_res,
  mcfb_cfg_if.sink   cfg_wr
);

  // Default register for request commands that carry none; resets to 80.
  logic [7:0] default_register_r, default_register_nxt;

  mcfb_rec_t f_rec, b_rec;
  logic      f_valid, f_ready, b_valid, b_ready;

  assign cfg_wr.ready = 1'b1;

  always_comb begin
    default_register_nxt = default_register_r;
    if (cfg_wr.valid) default_register_nxt = cfg_wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_register_r <= 8'd80;
    end else begin
      default_register_r <= default_register_nxt;
    end
  end

  // Front: classification, limit check and quantization of MIT targets.
  mcfb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_cmd),
    .default_register (default_register_r),
    .rec              (f_rec),
    .rec_valid        (f_valid),
    .rec_ready        (f_ready)
  );

  // Queue decouples command preparation from frame serialization.
  mcfb_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_rec   (f_rec),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_rec   (b_rec),
    .rd_valid (b_valid),
    .rd_ready (b_ready)
  );

  // Back: byte serializer with running checksum and output register.
  mcfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec       (b_rec),
    .rec_valid (b_valid),
    .rec_ready (b_ready),
    .out_res   (out_res)
  );

endmodule

// ===== src/mcfb_qdiv.sv =====
// ----------------------------------------------------------------------------
// mcfb_qdiv
// Division of a scaled dividend by a channel span through multiplication
// with the span's reciprocal, in two register stages.
// ----------------------------------------------------------------------------
module mcfb_qdiv
  import mcfb_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic              step,
  input  logic [QU_W-1:0]   u,
  input  logic [RCP_W-1:0]  m,
  output logic [QUO_W-1:0]  quo
);

  localparam int PW = QU_W + RCP_W;

  logic [QU_W-1:0]  u_r;
  logic [RCP_W-1:0] m_r;
  logic [PW-1:0]    prod_r;

  // The dividend stays below 2^22, so the truncated product is the exact floor.
  always_ff @(posedge clk) begin
    if (load) begin
      u_r <= u;
      m_r <= m;
    end
    if (step) begin
      prod_r <= PW'(u_r) * PW'(m_r);
    end
  end

  assign quo = prod_r[RCP_SH +: QUO_W];

endmodule

// ===== src/mcfb_front.sv =====
// ----------------------------------------------------------------------------
// mcfb_front
// Accepts commands, checks limits, quantizes MIT targets, builds the record.
// ----------------------------------------------------------------------------
module mcfb_front
  import mcfb_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic        clk,
  input  logic        rst_n,
  mcfb_cmd_if.sink    in_cmd,
  input  logic [7:0]  default_register,
  output mcfb_rec_t   rec,
  output logic        rec_valid,
  input  logic        rec_ready
);

  localparam int VW   = FRAC_BITS + 9;
  localparam int EW   = (FRAC_BITS + 10 > 33) ? FRAC_BITS + 10 : 33;
  localparam int NUMW = VW + 16;
  localparam int TW   = NUMW + 2;

  localparam logic [63:0] RND = 64'd1 << (31 - FRAC_BITS);
  localparam int          SH  = 32 - FRAC_BITS;
  localparam logic [63:0] LIM_PI  = (LIM_PI_Q32  + RND) >> SH;
  localparam logic [63:0] LIM_30  = (LIM_30_Q32  + RND) >> SH;
  localparam logic [63:0] LIM_40  = (LIM_40_Q32  + RND) >> SH;
  localparam logic [63:0] LIM_60  = (LIM_60_Q32  + RND) >> SH;
  localparam logic [63:0] LIM_135 = (LIM_135_Q32 + RND) >> SH;

  logic acc, push;
  logic pend_valid_r, pend_valid_nxt;
  logic load_r, load_nxt;
  logic busy_r, busy_nxt;
  logic [2:0] op_r, bus_r;
  logic [15:0] mid_r;
  logic [7:0] reg_r;
  logic [1:0] stat_r, stat_in;
  logic [VW-1:0] v_r [NCH];
  logic [VW-1:0] v_in [NCH];
  logic [DV_W-1:0] d_r [NCH];
  logic [DV_W-1:0] d_in [NCH];
  logic [RCP_W-1:0] m_r [NCH];
  logic [RCP_W-1:0] m_in [NCH];
  logic signed [31:0] x_in [NCH];
  logic [QUO_W-1:0] quo [NCH];
  logic [QU_W-1:0] u_ld [NCH];

  logic mid23, big;
  logic signed [EW-1:0] lim, q_e;

  // Input classification and clamping
  always_comb begin
    logic signed [EW-1:0] x_e, den_e, lo_e, hi_e;
    mid23 = (in_cmd.motor_number == 16'd2) || (in_cmd.motor_number == 16'd3);
    big   = (in_cmd.bus_number == BUS_SPINE) != mid23;
    if (in_cmd.bus_number == BUS_SPINE)    lim = signed'(EW'(LIM_40));
    else if (in_cmd.motor_number == 16'd1) lim = signed'(EW'(LIM_30));
    else if (in_cmd.motor_number == 16'd2) lim = signed'(EW'(LIM_60));
    else if (in_cmd.motor_number == 16'd3) lim = signed'(EW'(LIM_135));
    else                                   lim = signed'(EW'(LIM_PI));
    q_e = EW'(in_cmd.position_target);
    if (in_cmd.operation > OP_ZERO) stat_in = STAT_BADOP;
    else if (in_cmd.operation == OP_MIT && (q_e < -lim || q_e > lim)) stat_in = STAT_LIMIT;
    else stat_in = STAT_OK;

    x_in[0] = in_cmd.position_target;
    x_in[1] = in_cmd.velocity_target;
    x_in[2] = in_cmd.torque_target;
    x_in[3] = in_cmd.stiffness_gain;
    x_in[4] = in_cmd.damping_gain;
    d_in[0] = SPAN_POS;
    d_in[1] = big ? SPAN_VEL_BIG : SPAN_VEL_SML;
    d_in[2] = big ? SPAN_TAU_BIG : SPAN_TAU_SML;
    d_in[3] = SPAN_KP;
    d_in[4] = SPAN_KD;
    m_in[0] = RCP_POS;
    m_in[1] = big ? RCP_VEL_BIG : RCP_VEL_SML;
    m_in[2] = big ? RCP_TAU_BIG : RCP_TAU_SML;
    m_in[3] = RCP_KP;
    m_in[4] = RCP_KD;
    for (int c = 0; c < NCH; c++) begin
      x_e   = EW'(x_in[c]);
      den_e = EW'(d_in[c]) << (FRAC_BITS - 1);
      lo_e  = (c < 3) ? -(den_e >>> 1) : '0;
      hi_e  = lo_e + den_e;
      if (x_e < lo_e)      v_in[c] = '0;
      else if (x_e > hi_e) v_in[c] = VW'(den_e);
      else                 v_in[c] = VW'(x_e - lo_e);
    end
  end

  // Scaled dividend: round((v * (2^bits - 1)) / den) = floor((2 num + den) >> F) / span
  always_comb begin
    logic [NUMW-1:0] num;
    logic [TW-1:0]   t;
    logic [VW-1:0]   den;
    for (int c = 0; c < NCH; c++) begin
      den = VW'(d_r[c]) << (FRAC_BITS - 1);
      if (c == 0) num = (NUMW'(v_r[c]) << 16) - NUMW'(v_r[c]);
      else        num = (NUMW'(v_r[c]) << 12) - NUMW'(v_r[c]);
      t = (TW'(num) << 1) + TW'(den);
      u_ld[c] = t[FRAC_BITS +: QU_W];
    end
  end

  for (genvar g = 0; g < NCH; g++) begin : g_div
    mcfb_qdiv u_div (
      .clk  (clk),
      .load (load_r),
      .step (busy_r),
      .u    (u_ld[g]),
      .m    (m_r[g]),
      .quo  (quo[g])
    );
  end

  assign rec_valid     = pend_valid_r && !load_r && !busy_r;
  assign push          = rec_valid && rec_ready;
  assign in_cmd.ready  = !pend_valid_r || push;
  assign acc           = in_cmd.valid && in_cmd.ready;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    load_nxt       = 1'b0;
    busy_nxt       = busy_r;
    if (load_r) begin
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      busy_nxt = 1'b0;
    end
    if (push) pend_valid_nxt = 1'b0;
    if (acc) begin
      pend_valid_nxt = 1'b1;
      load_nxt       = (stat_in == STAT_OK) && (in_cmd.operation == OP_MIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      load_r       <= 1'b0;
      busy_r       <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      load_r       <= load_nxt;
      busy_r       <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r   <= in_cmd.operation;
      bus_r  <= in_cmd.bus_number;
      mid_r  <= in_cmd.motor_number;
      reg_r  <= in_cmd.register_given ? in_cmd.register_id : default_register;
      stat_r <= stat_in;
      for (int c = 0; c < NCH; c++) begin
        v_r[c] <= v_in[c];
        d_r[c] <= d_in[c];
        m_r[c] <= m_in[c];
      end
    end
  end

  // Record assembly
  always_comb begin
    rec.status = stat_r;
    rec.port   = (bus_r > 3'd2);
    unique case (bus_r)
      3'd3:    rec.bus = 3'd1;
      3'd4:    rec.bus = 3'd2;
      3'd5:    rec.bus = 3'd3;
      default: rec.bus = bus_r;
    endcase
    rec.canid = mid_r[10:0];
    rec.pay   = '0;
    unique case (op_r)
      OP_MIT: begin
        rec.pay[0] = quo[0][15:8];
        rec.pay[1] = quo[0][7:0];
        rec.pay[2] = quo[1][11:4];
        rec.pay[3] = {quo[1][3:0], quo[3][11:8]};
        rec.pay[4] = quo[3][7:0];
        rec.pay[5] = quo[4][11:4];
        rec.pay[6] = {quo[4][3:0], quo[2][11:8]};
        rec.pay[7] = quo[2][7:0];
      end
      OP_REQUEST: begin
        rec.pay[0] = mid_r[7:0];
        rec.pay[1] = mid_r[15:8];
        rec.pay[2] = REG_READ;
        rec.pay[3] = reg_r;
        rec.canid  = REQ_CANID;
      end
      OP_ENABLE: begin
        rec.pay[6:0] = {7{FILL_BYTE}};
        rec.pay[7]   = CODE_ENABLE;
      end
      OP_DISABLE: begin
        rec.pay[6:0] = {7{FILL_BYTE}};
        rec.pay[7]   = CODE_DISABLE;
      end
      OP_ZERO: begin
        rec.pay[6:0] = {7{FILL_BYTE}};
        rec.pay[7]   = CODE_ZERO;
      end
      default: rec.pay = '0;
    endcase
  end

endmodule

// ===== src/mcfb_fifo.sv =====
// ----------------------------------------------------------------------------
// mcfb_fifo
// Two-entry record queue between the front and the back.
// ----------------------------------------------------------------------------
module mcfb_fifo
  import mcfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  mcfb_rec_t wr_rec,
  input  logic      wr_valid,
  output logic      wr_ready,
  output mcfb_rec_t rd_rec,
  output logic      rd_valid,
  input  logic      rd_ready
);

  mcfb_rec_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_rec   = mem_r[rd_ptr_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr;
    rd_ptr_nxt = rd_ptr_r ^ rd;
    cnt_nxt    = cnt_r + 2'(wr) - 2'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wr_ptr_r] <= wr_rec;
  end

endmodule

// ===== src/mcfb_back.sv =====
// ----------------------------------------------------------------------------
// mcfb_back
// Serializes a record into frame bytes and computes the checksum.
// ----------------------------------------------------------------------------
module mcfb_back
  import mcfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mcfb_rec_t   rec,
  input  logic        rec_valid,
  output logic        rec_ready,
  mcfb_res_if.source  out_res
);

  logic [3:0] idx_r, idx_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r, byte_sel;
  logic       last_r, last_sel, port_r;
  logic [1:0] stat_r;
  logic       ld;
  logic [2:0] pay_idx;

  assign ld      = rec_valid && (!out_valid_r || out_res.ready);
  assign pay_idx = 3'(idx_r - IDX_PAY0);

  always_comb begin
    case (idx_r) inside
      IDX_SYNC0:              byte_sel = SYNC0;
      IDX_SYNC1:              byte_sel = SYNC1;
      IDX_BUS:                byte_sel = {5'd0, rec.bus};
      IDX_IDHI:               byte_sel = {5'd0, rec.canid[10:8]};
      IDX_IDLO:               byte_sel = rec.canid[7:0];
      [IDX_PAY0:IDX_PAY7]:    byte_sel = rec.pay[pay_idx];
      default:                byte_sel = sum_r;
    endcase
    last_sel = (idx_r == IDX_SUM);
    if (rec.status != STAT_OK) begin
      byte_sel = 8'd0;
      last_sel = 1'b1;
    end
  end

  assign rec_ready = ld && last_sel;

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    if (ld) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = last_sel ? IDX_SYNC0 : idx_r + 4'd1;
      if (idx_r == IDX_BUS) sum_nxt = byte_sel;
      else                  sum_nxt = sum_r + byte_sel;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= IDX_SYNC0;
      sum_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      byte_r <= byte_sel;
      last_r <= last_sel;
      port_r <= rec.port;
      stat_r <= rec.status;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.out_byte    = byte_r;
  assign out_res.last_byte   = last_r;
  assign out_res.serial_port = port_r;
  assign out_res.status      = stat_r;

endmodule

// ===== src/mcfb_checker.sv =====
// ----------------------------------------------------------------------------
// mcfb_checker
// Port-level checks of the frame builder result stream.
// ----------------------------------------------------------------------------
module mcfb_checker
  import mcfb_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_byte,
  input logic [1:0] status
);

  // A rejection is a single zero byte that closes its own transaction group.
  a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != STAT_OK |-> last_byte && out_byte == 8'd0)
    else $error("rejection result not a single zero byte");

  // Any byte that is not the last belongs to a frame that is being sent.
  a_mid_frame_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_byte |-> status == STAT_OK)
    else $error("non-final byte carries a rejection status");

  // A stalled result holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_byte))
    else $error("stalled result changed");

endmodule

bind motor_command_frame_builder_unit mcfb_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_byte  (out_res.out_byte),
  .last_byte (out_res.last_byte),
  .status    (out_res.status)
);
